### src/dgs_pkg.sv
package dgs_pkg;

    localparam logic [3:0] GLYPH_MINUS = 4'd10;
    localparam logic [3:0] GLYPH_COMMA = 4'd11;
    localparam int GROUP_SIZE = 3;

    // Requests from the glyph sequencer to the conversion unit.
    typedef struct packed {
        logic load;
        logic shift_digit;
    } conv_ctrl_t;

    // What the conversion unit reports back.
    typedef struct packed {
        logic       done;
        logic       negative;
        logic [3:0] top_digit;
    } conv_stat_t;

endpackage

### src/dgs_convert.sv
module dgs_convert #(
    parameter int VALUE_BITS = 32,
    parameter int NDIG       = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dgs_pkg::conv_ctrl_t    ctrl,
    input  logic [VALUE_BITS-1:0]  value,
    output dgs_pkg::conv_stat_t    stat
);

    localparam int CW = $clog2(VALUE_BITS);
    localparam int BW = 4 * NDIG;

    logic                  running_reg, running_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  neg_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [BW-1:0]         bcd_reg;
    logic [BW-1:0]         bcd_adj;

    // One shift-and-add-3 step of the double dabble conversion per cycle.
    always_comb
    begin
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        if (ctrl.load)
        begin
            running_next = 1'b1;
            cnt_next     = CW'(VALUE_BITS - 1);
        end
        else if (running_reg)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    // The magnitude is taken as unsigned, so the most negative value converts exactly.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            neg_reg <= value[VALUE_BITS-1];
            mag_reg <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
            bcd_reg <= '0;
        end
        else if (running_reg)
        begin
            mag_reg <= {mag_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BW-2:0], mag_reg[VALUE_BITS-1]};
        end
        else if (ctrl.shift_digit)
        begin
            bcd_reg <= {bcd_reg[BW-5:0], 4'd0};
        end
    end

    assign stat.done      = done_reg;
    assign stat.negative  = neg_reg;
    assign stat.top_digit = bcd_reg[BW-1 -: 4];

endmodule

### src/dgs_emit.sv
module dgs_emit #(
    parameter int NDIG = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 comma_en,
    input  dgs_pkg::conv_stat_t  stat,
    output dgs_pkg::conv_ctrl_t  ctrl,
    output logic                 busy,
    output logic                 strobe,
    output logic [3:0]           glyph,
    output logic                 last
);

    localparam int PW = $clog2(NDIG);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_SKIP,
        S_DIGIT,
        S_COMMA
    } state_t;

    state_t        state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [1:0]    grp_reg, grp_next;
    logic          strobe_reg, strobe_next;
    logic [3:0]    glyph_reg, glyph_next;
    logic          last_reg, last_next;
    logic [1:0]    grp_dec;

    // grp_reg tracks pos_reg modulo the group size.
    assign grp_dec = (grp_reg == 2'd0) ? 2'(dgs_pkg::GROUP_SIZE - 1) : grp_reg - 2'd1;

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        grp_next         = grp_reg;
        strobe_next      = 1'b0;
        glyph_next       = glyph_reg;
        last_next        = 1'b0;
        ctrl.load        = 1'b0;
        ctrl.shift_digit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (stat.done)
                begin
                    pos_next   = PW'(NDIG - 1);
                    grp_next   = 2'((NDIG - 1) % dgs_pkg::GROUP_SIZE);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Leading zeros are dropped, but the units digit always shows.
                if (stat.top_digit == 4'd0 && pos_reg != '0)
                begin
                    ctrl.shift_digit = 1'b1;
                    pos_next         = pos_reg - PW'(1);
                    grp_next         = grp_dec;
                end
                else
                begin
                    if (stat.negative)
                    begin
                        strobe_next = 1'b1;
                        glyph_next  = dgs_pkg::GLYPH_MINUS;
                    end
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                strobe_next = 1'b1;
                glyph_next  = stat.top_digit;
                if (pos_reg == '0)
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctrl.shift_digit = 1'b1;
                    pos_next         = pos_reg - PW'(1);
                    grp_next         = grp_dec;
                    if (comma_en && grp_reg == 2'd0)
                        state_next = S_COMMA;
                end
            end
            S_COMMA:
            begin
                strobe_next = 1'b1;
                glyph_next  = dgs_pkg::GLYPH_COMMA;
                state_next  = S_DIGIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            grp_reg    <= '0;
            strobe_reg <= 1'b0;
            glyph_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            grp_reg    <= grp_next;
            strobe_reg <= strobe_next;
            glyph_reg  <= glyph_next;
            last_reg   <= last_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign glyph  = glyph_reg;
    assign last   = last_reg;

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |=> !strobe_reg)
        else $error("glyph emitted right after the final glyph of an item");

    a_comma_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && glyph_reg == dgs_pkg::GLYPH_COMMA |=>
            strobe_reg && !last_reg && glyph_reg <= 4'd9)
        else $error("comma not followed by a digit");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe_reg && last_reg)
        else $error("sequencer went idle without a final glyph");

    a_comma_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |-> glyph_reg <= 4'd9)
        else $error("final glyph of an item is not a digit");

endmodule

### src/decimal_glyph_sequencer.sv
// After start is accepted, the conversion unit runs one double dabble step per cycle; the
// sequencer then skips leading zero digits and emits glyphs one per cycle, up to 14 of them
// at 32 bits (sign, ten digits and three commas).
// A new start is taken only while idle; busy stays high until the final glyph of an item.
// Results are strobed for exactly one cycle and cannot be held off by the receiver.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears the comma enable.
module decimal_glyph_sequencer #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  strobe,
    output logic [3:0]            glyph,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);

    // Decimal digits needed for the largest magnitude.
    localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;

    logic                 comma_en_reg;
    logic                 accept;
    dgs_pkg::conv_ctrl_t  ctrl;
    dgs_pkg::conv_stat_t  stat;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            comma_en_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            comma_en_reg <= cfg_data;
    end

    dgs_convert #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_convert (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .value (value),
        .stat  (stat)
    );

    dgs_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .comma_en (comma_en_reg),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy),
        .strobe   (strobe),
        .glyph    (glyph),
        .last     (last)
    );

endmodule
